// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the top-level design file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/ulw_pkg.sv =====
// ---------------------------------------------------------------------------
// ulw_pkg
// Types, constants and helpers of the UTF-8 line wrap mapper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ulw_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int OUT_OFS_W   = 16;
  localparam int IDX_W       = 16;
  localparam int COL_W       = 10;
  localparam int ROLE_W      = 4;
  localparam int BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;

  localparam logic [COL_W-1:0]  WIDTH_RESET  = 10'd80;
  localparam logic [COL_W-1:0]  COL_MAX      = {COL_W{1'b1}};

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] ofs_t;

  typedef struct packed {
    logic              has_byte;
    logic [BYTE_W-1:0] text_byte;
    logic              ends_message;
    logic [ROLE_W-1:0] message_role;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] msg_cnt;
    ofs_t             byte_pos;
    ofs_t             line_base;
    logic [COL_W-1:0] column;
    logic             line_open;
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0]     message_index;
    logic [OUT_OFS_W-1:0] start_offset;
    logic [OUT_OFS_W-1:0] end_offset;
    logic [COL_W-1:0]     chars;
    logic [ROLE_W-1:0]    line_role;
    logic                 last_of_run;
  } rec_t;

  // Offsets stop at the all-ones value.
  function automatic ofs_t sat_inc(input ofs_t v);
    ofs_t r;
    if (v == {OFFSET_BITS{1'b1}}) begin
      r = v;
    end else begin
      r = v + ofs_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== design/ulw_step.sv =====
// ---------------------------------------------------------------------------
// ulw_step
// Per-item next state and up to two line records for one input request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ulw_step
  import ulw_pkg::*;
(
  input  item_t            item,
  input  state_t           st,
  input  logic [COL_W-1:0] line_width,
  output state_t           st_nxt,
  output rec_t             rec0,
  output rec_t             rec1,
  output logic [1:0]       rec_n
);

  logic [COL_W-1:0] w_eff;
  logic             is_char;
  logic             a_v;
  logic             b_v;
  ofs_t             a_start;
  ofs_t             a_end;
  logic [COL_W-1:0] a_cnt;
  ofs_t             b_start;
  ofs_t             b_end;
  logic [COL_W-1:0] b_cnt;
  ofs_t             ls_t;
  ofs_t             bp_t;
  logic [COL_W-1:0] col_t;
  logic             open_t;
  logic [IDX_W-1:0] msg_t;

  assign w_eff   = (line_width == '0) ? COL_W'(1) : line_width;
  assign is_char = (item.text_byte & CONT_MASK) != CONT_TAG;

  always_comb begin
    ls_t    = st.line_base;
    bp_t    = st.byte_pos;
    col_t   = st.column;
    open_t  = st.line_open;
    msg_t   = st.msg_cnt;
    a_v     = 1'b0;
    a_start = st.line_base;
    a_end   = st.byte_pos;
    a_cnt   = st.column;

    if (item.has_byte) begin
      if (item.text_byte == NEWLINE_BYTE) begin
        a_v    = 1'b1;
        ls_t   = sat_inc(st.byte_pos);
        col_t  = '0;
        open_t = 1'b0;
      end else begin
        // A lead byte on a full line starts a new line at this byte.
        if (is_char && (st.column >= w_eff)) begin
          a_v   = 1'b1;
          ls_t  = st.byte_pos;
          col_t = '0;
        end
        if (is_char && (col_t != COL_MAX)) begin
          col_t = col_t + COL_W'(1);
        end
        open_t = 1'b1;
      end
      bp_t = sat_inc(st.byte_pos);
    end

    b_v     = 1'b0;
    b_start = ls_t;
    b_end   = bp_t;
    b_cnt   = col_t;
    if (item.ends_message) begin
      // An empty message still reports one empty line.
      if (!item.has_byte && (st.byte_pos == '0) && !st.line_open) begin
        b_v     = 1'b1;
        b_start = '0;
        b_end   = '0;
        b_cnt   = '0;
      end else if (open_t) begin
        b_v = 1'b1;
      end
      msg_t  = st.msg_cnt + IDX_W'(1);
      bp_t   = '0;
      ls_t   = '0;
      col_t  = '0;
      open_t = 1'b0;
    end

    st_nxt.msg_cnt    = msg_t;
    st_nxt.byte_pos   = bp_t;
    st_nxt.line_base  = ls_t;
    st_nxt.column     = col_t;
    st_nxt.line_open  = open_t;

    rec1.message_index = st.msg_cnt;
    rec1.start_offset  = OUT_OFS_W'(b_start);
    rec1.end_offset    = OUT_OFS_W'(b_end);
    rec1.chars         = b_cnt;
    rec1.line_role     = item.message_role;
    rec1.last_of_run   = 1'b1;

    if (a_v) begin
      rec0.message_index = st.msg_cnt;
      rec0.start_offset  = OUT_OFS_W'(a_start);
      rec0.end_offset    = OUT_OFS_W'(a_end);
      rec0.chars         = a_cnt;
      rec0.line_role     = item.message_role;
      rec0.last_of_run   = !b_v;
    end else begin
      rec0 = rec1;
    end

    rec_n = {1'b0, a_v} + {1'b0, b_v};
  end

endmodule

// ===== design/ulw_out_fifo.sv =====
// ---------------------------------------------------------------------------
// ulw_out_fifo
// Small record queue; takes up to two records a cycle, gives one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ulw_out_fifo
  import ulw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  rec_t             push0,
  input  rec_t             push1,
  input  logic             pop,
  output rec_t             head,
  output logic [CNT_W-1:0] count,
  output logic             room2
);

  rec_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign cnt_nxt    = cnt_r + CNT_W'(push_n) - CNT_W'(pop);

  assign head  = mem_r[rd_ptr_r];
  assign count = cnt_r;
  assign room2 = cnt_r <= CNT_W'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

endmodule

// ===== design/utf8_line_wrap_mapper_top.sv =====
// ---------------------------------------------------------------------------
// utf8_line_wrap_mapper_top
// Cuts a stream of UTF-8 message bytes into display line records.
//
// Input channel (in_*): one request per text byte, or an empty-message
// marker with in_has_byte low, tagged with role and end-of-message flag.
// Output channel (out_*): one request per line record; out_last_of_run
// marks the final record caused by an input request.
// Config channel (cfg_*): writes line_width; always ready. line_width must be
// written only while the block is idle; the block does not enforce this.
// An input request is held in a request register; its records are then written
// into the record queue that drives out_*, and a full queue can hold them back.
// Throughput: one input request per cycle while each causes at most one
// record and the receiver does not stall; a request that causes two records
// is held back by the single output port behind a four-entry record queue.
// Reset clears all counters, empties the queue and sets line_width to 80.
// When the receiver stalls, the queue fills and in_stall rises while a held
// request cannot fit two more records; no request or record is ever dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module utf8_line_wrap_mapper_top
  import ulw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_has_byte,
  input  logic [BYTE_W-1:0]    in_text_byte,
  input  logic                 in_ends_message,
  input  logic [ROLE_W-1:0]    in_message_role,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     out_message_index,
  output logic [OUT_OFS_W-1:0] out_start_offset,
  output logic [OUT_OFS_W-1:0] out_end_offset,
  output logic [COL_W-1:0]     out_char_count,
  output logic [ROLE_W-1:0]    out_line_role,
  output logic                 out_last_of_run,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [COL_W-1:0]     cfg_line_width
);

  logic [COL_W-1:0] width_r;
  item_t            item_r;
  item_t            item_nxt;
  logic             item_vld_r;
  logic             item_vld_nxt;
  state_t           st_r;
  state_t           st_nxt;
  rec_t             rec0;
  rec_t             rec1;
  logic [1:0]       rec_n;
  logic [1:0]       push_n;
  logic             proc;
  logic             in_acc;
  logic             pop;
  rec_t             head;
  logic [CNT_W-1:0] q_count;
  logic             q_room2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_r <= cfg_line_width;
    end
  end

  // The held request is processed once the queue can take two records.
  assign proc     = item_vld_r && q_room2;
  assign in_stall = item_vld_r && !q_room2;
  assign in_acc   = in_valid && !in_stall;

  assign item_nxt.has_byte     = in_has_byte;
  assign item_nxt.text_byte    = in_text_byte;
  assign item_nxt.ends_message = in_ends_message;
  assign item_nxt.message_role = in_message_role;
  assign item_vld_nxt          = in_acc || (item_vld_r && !proc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      st_r       <= '0;
    end else begin
      item_vld_r <= item_vld_nxt;
      if (proc) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= item_nxt;
    end
  end

  ulw_step u_step (
    .item       (item_r),
    .st         (st_r),
    .line_width (width_r),
    .st_nxt     (st_nxt),
    .rec0       (rec0),
    .rec1       (rec1),
    .rec_n      (rec_n)
  );

  assign push_n = proc ? rec_n : 2'd0;
  assign pop    = out_valid && !out_stall;

  ulw_out_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .push0  (rec0),
    .push1  (rec1),
    .pop    (pop),
    .head   (head),
    .count  (q_count),
    .room2  (q_room2)
  );

  assign out_valid         = q_count != '0;
  assign out_message_index = head.message_index;
  assign out_start_offset  = head.start_offset;
  assign out_end_offset    = head.end_offset;
  assign out_char_count    = head.chars;
  assign out_line_role     = head.line_role;
  assign out_last_of_run   = head.last_of_run;

  `ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1, q_count <= CNT_W'(FIFO_DEPTH))
  `ASSERT_IMPLY(a_push_room, clk, rst_n, push_n != 2'd0, q_room2 && item_vld_r)
  `ASSERT_NEXT(a_held_kept, clk, rst_n, item_vld_r && !proc, item_vld_r && $stable(item_r))
  `ASSERT_IMPLY(a_rec_bound, clk, rst_n, item_vld_r, rec_n != 2'd3)

endmodule
